// File: rtl/thermal_fan_controller_defines.svh
// Assertion macros for the thermal fan controller.
// Included by files that check their own logic; depends on nothing else.
`ifndef THERMAL_FAN_CONTROLLER_DEFINES_SVH
`define THERMAL_FAN_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define TFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tfc assertion failed");
// Check that a condition leads to another one in the next cycle.
`define TFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tfc assertion failed");
`else
`define TFC_ASSERT(label, prop)
`define TFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/tfc_pkg.sv
// Shared types and constants of the thermal fan controller.
// No dependencies; imported by every module of the block.
package tfc_pkg;

  localparam int unsigned DutyW      = 7;
  localparam int unsigned TempW      = 8;
  localparam int unsigned TimerW     = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned NumPresets = 4;

  localparam logic [DutyW-1:0] DUTY_MAX  = 7'd100;
  localparam logic [DutyW-1:0] DUTY_STEP = 7'd5;
  // Duty is the excess shifted left by this amount (gain of four).
  localparam int unsigned      TEMP_GAIN_SHIFT = 2;
  // Excess at and above which the gained duty reaches its ceiling.
  localparam logic [DutyW-1:0] EXCESS_SAT = 7'(100 / 4);
  localparam logic [ModeW-1:0] TIMER_MODE_TOP = 2'd3;
  localparam logic [ModeW-1:0] TIMER_MODE_OFF = 2'd0;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_TOGGLE      = 3'd1,
    REQ_DUTY_UP     = 3'd2,
    REQ_DUTY_DOWN   = 3'd3,
    REQ_TIMER_PLUS  = 3'd4,
    REQ_TIMER_MINUS = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_LIMIT = 2'd1,
    BEEP_GOOD  = 2'd2,
    BEEP_BAD   = 2'd3
  } beep_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_MODE = 3'd0,
    CFG_SET_TEMP  = 3'd1,
    CFG_PRESET_0  = 3'd2,
    CFG_PRESET_1  = 3'd3,
    CFG_PRESET_2  = 3'd4,
    CFG_PRESET_3  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                              auto_mode;
    logic [6:0]                        setpoint;
    logic [NumPresets-1:0][TimerW-1:0] preset;
  } tfc_cfg_t;

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic              fan_on;
    logic [ModeW-1:0]  timer_mode;
    logic [TimerW-1:0] timer_rem;
  } tfc_state_t;

  typedef struct packed {
    logic  pwm_update;
    beep_e beep;
  } tfc_flags_t;

endpackage

// File: rtl/tfc_cfg_regs.sv
// Configuration registers of the thermal fan controller.
// Depends on tfc_pkg.
module tfc_cfg_regs
  import tfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output tfc_cfg_t            cfg_o
);

  tfc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_AUTO_MODE: cfg_d.auto_mode = data_i[0];
        CFG_SET_TEMP:  cfg_d.setpoint  = data_i[6:0];
        CFG_PRESET_0:  cfg_d.preset[0] = data_i;
        CFG_PRESET_1:  cfg_d.preset[1] = data_i;
        CFG_PRESET_2:  cfg_d.preset[2] = data_i;
        CFG_PRESET_3:  cfg_d.preset[3] = data_i;
        default:       cfg_d = cfg_q;   // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_mode <= 1'b0;
      cfg_q.setpoint  <= 7'd75;
      cfg_q.preset[0] <= 8'd0;
      cfg_q.preset[1] <= 8'd30;
      cfg_q.preset[2] <= 8'd60;
      cfg_q.preset[3] <= 8'd120;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tfc_step.sv
// Next-state logic of the thermal fan controller for one request.
// Purely combinational; depends on tfc_pkg.
module tfc_step
  import tfc_pkg::*;
(
  input  tfc_cfg_t          cfg_i,
  input  tfc_state_t        state_i,
  input  logic [2:0]        req_i,
  input  logic [TempW-1:0]  temp_i,
  output tfc_state_t        state_o,
  output tfc_flags_t        flags_o
);

  logic signed [TempW:0] excess;
  logic [DutyW-1:0]      auto_duty;
  logic [DutyW-1:0]      duty_up;
  logic [TimerW-1:0]     rem_dec;
  logic [ModeW-1:0]      mode_inc;
  logic [ModeW-1:0]      mode_dec;

  // Excess over the set point, one bit wider so the sign survives.
  assign excess = $signed({temp_i[TempW-1], temp_i}) - $signed({2'b00, cfg_i.setpoint});

  always_comb begin
    if (excess[TempW]) begin
      auto_duty = '0;
    end else if (excess[DutyW-1:0] >= EXCESS_SAT) begin
      auto_duty = DUTY_MAX;
    end else begin
      auto_duty = {excess[DutyW-1-TEMP_GAIN_SHIFT:0], {TEMP_GAIN_SHIFT{1'b0}}};
    end
  end

  assign duty_up  = (state_i.duty + DUTY_STEP > DUTY_MAX) ? DUTY_MAX
                                                         : state_i.duty + DUTY_STEP;
  assign rem_dec  = (state_i.timer_rem != '0) ? state_i.timer_rem - 1'b1 : '0;
  assign mode_inc = state_i.timer_mode + 1'b1;
  assign mode_dec = state_i.timer_mode - 1'b1;

  always_comb begin
    state_o            = state_i;
    flags_o.pwm_update = 1'b0;
    flags_o.beep       = BEEP_NONE;
    unique case (req_e'(req_i))
      REQ_TICK: begin
        if (cfg_i.auto_mode) begin
          state_o.duty       = auto_duty;
          flags_o.pwm_update = 1'b1;
        end
        if (state_i.timer_mode != TIMER_MODE_OFF) begin
          state_o.timer_rem = rem_dec;
          if (rem_dec == '0) begin
            state_o.timer_mode = TIMER_MODE_OFF;
            state_o.fan_on     = 1'b0;
          end
        end
      end
      REQ_TOGGLE: begin
        state_o.fan_on     = !state_i.fan_on;
        flags_o.pwm_update = !state_i.fan_on;
      end
      REQ_DUTY_UP: begin
        if (!cfg_i.auto_mode) begin
          if (state_i.duty >= DUTY_MAX) begin
            state_o.duty = DUTY_MAX;
            flags_o.beep = BEEP_LIMIT;
          end else begin
            state_o.duty = duty_up;
          end
          flags_o.pwm_update = 1'b1;
        end
      end
      REQ_DUTY_DOWN: begin
        if (state_i.duty == '0) begin
          flags_o.beep = BEEP_LIMIT;
        end else begin
          state_o.duty = (state_i.duty >= DUTY_STEP) ? state_i.duty - DUTY_STEP : '0;
        end
        flags_o.pwm_update = 1'b1;
      end
      REQ_TIMER_PLUS: begin
        if (state_i.timer_mode < TIMER_MODE_TOP) begin
          state_o.timer_mode = mode_inc;
          state_o.timer_rem  = cfg_i.preset[mode_inc];
          flags_o.beep       = BEEP_GOOD;
        end else begin
          flags_o.beep = BEEP_BAD;
        end
      end
      REQ_TIMER_MINUS: begin
        if (state_i.timer_mode == TIMER_MODE_OFF) begin
          flags_o.beep = BEEP_BAD;
        end else begin
          state_o.timer_mode = mode_dec;
          state_o.timer_rem  = cfg_i.preset[mode_dec];
          flags_o.beep       = BEEP_GOOD;
        end
      end
      default: ;  // unused request codes leave everything as is
    endcase
  end

endmodule

// File: rtl/thermal_fan_controller.sv
// Thermal fan controller top level: request register, step logic, result register.
// Depends on tfc_pkg, tfc_cfg_regs, tfc_step and thermal_fan_controller_defines.svh.
//
// Usage:
//   Requests enter on the s_axis channel: s_axis_tuser carries the request type
//   (tick, toggle, duty up/down, timer plus/minus), s_axis_tdata the signed
//   temperature that a tick uses. Every request yields exactly one result on
//   the m_axis channel: duty, fan enable, PWM load flag, beep code, timer mode
//   and remaining countdown after that request.
//   A taken request is held in the request register and moves to the result
//   register once that slot is free. Throughput is one request per cycle while
//   the receiver keeps up; the step logic between the two registers is combinational.
//   When the receiver stalls, the result register holds, the request register
//   fills, and only then does s_axis_tready drop; a new request is taken in
//   the same cycle the pending one moves forward.
//   Reset clears duty, fan, timer mode and countdown and loads the default
//   configuration (manual mode, set point 75, presets 0/30/60/120).
//   Configuration writes on cfg_we_i take effect at the next clock edge and
//   are meant to arrive while no request is in flight.

`include "thermal_fan_controller_defines.svh"

module thermal_fan_controller
  import tfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] temperature
  input  logic [2:0]          s_axis_tuser,   // [2:0] req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [6:0] duty_out, [7] fan_enabled, [8] pwm_update, [10:9] beep_code,
  // [12:11] timer_mode_out, [20:13] timer_left, [23:21] zero
  output logic [23:0]         m_axis_tdata
);

  tfc_cfg_t   cfg;
  tfc_state_t state_q, state_d;
  tfc_flags_t flags_q, flags_d;

  logic             in_vld_q;
  logic [2:0]       in_req_q;
  logic [TempW-1:0] in_temp_q;
  logic             out_vld_q;
  logic             advance;
  logic             in_take;

  tfc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Move the held request into the result slot when that slot is free or
  // being drained this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Request payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q  <= s_axis_tuser;
      in_temp_q <= s_axis_tdata;
    end
  end

  tfc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (in_req_q),
    .temp_i  (in_temp_q),
    .state_o (state_d),
    .flags_o (flags_d)
  );

  // The controller state only moves when a result is loaded, so the state
  // registers double as the payload of the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, state_q.timer_rem, state_q.timer_mode, flags_q.beep,
                          flags_q.pwm_update, state_q.fan_on, state_q.duty};

  // Duty never leaves its percent range.
  `TFC_ASSERT(a_duty_range, state_q.duty <= DUTY_MAX)
  // A held request with a free result slot is delivered in the next cycle.
  `TFC_ASSERT_NEXT(a_advance_fills, in_vld_q && !out_vld_q, out_vld_q)
  // An empty request register always takes a new request.
  `TFC_ASSERT(a_ready_when_empty, !in_vld_q |-> s_axis_tready)
  // Timer refusals never ask the PWM generator to reload.
  `TFC_ASSERT(a_bad_no_pwm, out_vld_q && (flags_q.beep == BEEP_BAD) |-> !flags_q.pwm_update)

endmodule

// File: tb/tfc_checker.sv
// Result checker for the thermal fan controller: follows the configuration port
// and both stream channels, predicts every result and compares it field by field.
// Depends on tfc_pkg.
module tfc_checker
  import tfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] temperature
  input  logic [2:0]          s_axis_tuser,   // [2:0] req_type
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [6:0] duty_out, [7] fan_enabled, [8] pwm_update, [10:9] beep_code,
  // [12:11] timer_mode_out, [20:13] timer_left
  input  logic [23:0]         m_axis_tdata,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEMP_GAIN  = 4;
  localparam int MAX_REPORT = 30;

  typedef struct {
    logic [DutyW-1:0]  duty;
    logic              fan;
    logic              pwm;
    beep_e             beep;
    logic [ModeW-1:0]  mode;
    logic [TimerW-1:0] left;
  } fan_status_t;

  tfc_cfg_t    fan_cfg;
  tfc_state_t  fan_state;
  fan_status_t status_q[$];
  int          reported;

  // Advance the controller copy by one request and return its status.
  function automatic fan_status_t apply_request(logic [2:0] kind_raw, logic [7:0] temp_raw);
    fan_status_t st;
    req_e        kind;
    int          temp;
    int          level;
    st.pwm  = 1'b0;
    st.beep = BEEP_NONE;
    kind    = req_e'(kind_raw);
    case (kind)
      REQ_TICK: begin
        if (fan_cfg.auto_mode) begin
          temp = int'($signed(temp_raw));
          if (temp < int'(fan_cfg.setpoint)) begin
            level = 0;
          end else begin
            level = (temp - int'(fan_cfg.setpoint)) * TEMP_GAIN;
          end
          if (level > int'(DUTY_MAX)) level = int'(DUTY_MAX);
          fan_state.duty = DutyW'(level);
          st.pwm = 1'b1;
        end
        if (fan_state.timer_mode != TIMER_MODE_OFF) begin
          if (fan_state.timer_rem != '0) fan_state.timer_rem = fan_state.timer_rem - 1'b1;
          if (fan_state.timer_rem == '0) begin
            fan_state.timer_mode = TIMER_MODE_OFF;
            fan_state.fan_on     = 1'b0;
          end
        end
      end
      REQ_TOGGLE: begin
        if (fan_state.fan_on) begin
          fan_state.fan_on = 1'b0;
        end else begin
          fan_state.fan_on = 1'b1;
          st.pwm = 1'b1;
        end
      end
      REQ_DUTY_UP: begin
        if (!fan_cfg.auto_mode) begin
          if (fan_state.duty >= DUTY_MAX) begin
            fan_state.duty = DUTY_MAX;
            st.beep = BEEP_LIMIT;
          end else begin
            level = int'(fan_state.duty) + int'(DUTY_STEP);
            if (level > int'(DUTY_MAX)) level = int'(DUTY_MAX);
            fan_state.duty = DutyW'(level);
          end
          st.pwm = 1'b1;
        end
      end
      REQ_DUTY_DOWN: begin
        if (fan_state.duty == '0) begin
          st.beep = BEEP_LIMIT;
        end else if (fan_state.duty >= DUTY_STEP) begin
          fan_state.duty = fan_state.duty - DUTY_STEP;
        end else begin
          fan_state.duty = '0;
        end
        st.pwm = 1'b1;
      end
      REQ_TIMER_PLUS: begin
        if (fan_state.timer_mode < TIMER_MODE_TOP) begin
          fan_state.timer_mode = fan_state.timer_mode + 1'b1;
          fan_state.timer_rem  = fan_cfg.preset[fan_state.timer_mode];
          st.beep = BEEP_GOOD;
        end else begin
          st.beep = BEEP_BAD;
        end
      end
      REQ_TIMER_MINUS: begin
        if (fan_state.timer_mode == TIMER_MODE_OFF) begin
          st.beep = BEEP_BAD;
        end else begin
          fan_state.timer_mode = fan_state.timer_mode - 1'b1;
          fan_state.timer_rem  = fan_cfg.preset[fan_state.timer_mode];
          st.beep = BEEP_GOOD;
        end
      end
      default: begin
        // unused request codes leave everything as it is
      end
    endcase
    st.duty = fan_state.duty;
    st.fan  = fan_state.fan_on;
    st.mode = fan_state.timer_mode;
    st.left = fan_state.timer_rem;
    return st;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_count_o++;
      if (reported < MAX_REPORT) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        reported++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fan_status_t want;
    fan_status_t got;
    if (!rst_ni) begin
      fan_cfg.auto_mode = 1'b0;
      fan_cfg.setpoint  = 7'd75;
      fan_cfg.preset[0] = 8'd0;
      fan_cfg.preset[1] = 8'd30;
      fan_cfg.preset[2] = 8'd60;
      fan_cfg.preset[3] = 8'd120;
      fan_state    = '0;
      status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      reported     = 0;
    end else begin
      // A result can never belong to a request taken at this same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got.duty = m_axis_tdata[6:0];
        got.fan  = m_axis_tdata[7];
        got.pwm  = m_axis_tdata[8];
        got.beep = beep_e'(m_axis_tdata[10:9]);
        got.mode = m_axis_tdata[12:11];
        got.left = m_axis_tdata[20:13];
        if (status_q.size() == 0) begin
          fail_count_o++;
          if (reported < MAX_REPORT) begin
            $display("%0t ns: result with nothing outstanding, expected none, got %h",
                     $time, m_axis_tdata);
            reported++;
          end
        end else begin
          want = status_q.pop_front();
          check_field("duty_out", want.duty, got.duty);
          check_field("fan_enabled", want.fan, got.fan);
          check_field("pwm_update", want.pwm, got.pwm);
          check_field("beep_code", want.beep, got.beep);
          check_field("timer_mode_out", want.mode, got.mode);
          check_field("timer_left", want.left, got.left);
          checked_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AUTO_MODE: fan_cfg.auto_mode = cfg_data_i[0];
          CFG_SET_TEMP:  fan_cfg.setpoint  = cfg_data_i[6:0];
          CFG_PRESET_0:  fan_cfg.preset[0] = cfg_data_i;
          CFG_PRESET_1:  fan_cfg.preset[1] = cfg_data_i;
          CFG_PRESET_2:  fan_cfg.preset[2] = cfg_data_i;
          CFG_PRESET_3:  fan_cfg.preset[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(apply_request(s_axis_tuser, s_axis_tdata));
      end
      pending_o = status_q.size();
    end
  end

endmodule

// File: tb/tb_thermal_fan_controller.sv
// Testbench top for the thermal fan controller: clock, reset, configuration
// phases and request stimulus. Depends on tfc_pkg, thermal_fan_controller and tfc_checker.
module tb_thermal_fan_controller;
  import tfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes the block has no operation for; it must leave its state alone.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] temperature
  logic [2:0]          s_axis_tuser;   // [2:0] req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [6:0] duty_out, [7] fan_enabled, [8] pwm_update, [10:9] beep_code,
  // [12:11] timer_mode_out, [20:13] timer_left, [23:21] zero
  logic [23:0]         m_axis_tdata;

  int fail_count;
  int pending;
  int checked;

  // Sender and receiver bookkeeping.
  int burst_left = 0;
  int kind_seen[8];
  int settings_done = 0;
  int cur_setpoint  = 75;
  bit rx_open = 1'b0;
  int rx_left = 0;

  thermal_fan_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tfc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // 4 ns clock, low half first.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: alternate open windows and stalls of random length; now and then
  // hold ready high for a long stretch so back-to-back results get through.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_open = !rx_open;
      if (rx_open) begin
        rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      end else begin
        rx_left = $urandom_range(1, 8);
      end
    end
    rx_left--;
    m_axis_tready <= rx_open;
  end

  // Issue one request and hold it until the block takes it. Before each burst
  // drop valid for a random gap, sometimes none at all.
  task automatic send_req(input logic [2:0] kind, input logic [7:0] temp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= temp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    kind_seen[kind]++;
  endtask

  // Drop valid and wait until every outstanding result has come back, then
  // let the two-stage pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Write all six registers; only call with the block idle.
  task automatic apply_setting(input logic auto_on, input logic [6:0] set_point,
                               input logic [7:0] p0, input logic [7:0] p1,
                               input logic [7:0] p2, input logic [7:0] p3);
    write_reg(CFG_AUTO_MODE, {7'd0, auto_on});
    write_reg(CFG_SET_TEMP, {1'b0, set_point});
    write_reg(CFG_PRESET_0, p0);
    write_reg(CFG_PRESET_1, p1);
    write_reg(CFG_PRESET_2, p2);
    write_reg(CFG_PRESET_3, p3);
    cur_setpoint = set_point;
    settings_done++;
  endtask

  // Small presets make the shutoff timer expire often; full range covers every bit.
  function automatic logic [7:0] pick_preset();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return REQ_TICK;
    if (roll < 50) return REQ_TOGGLE;
    if (roll < 62) return REQ_DUTY_UP;
    if (roll < 74) return REQ_DUTY_DOWN;
    if (roll < 85) return REQ_TIMER_PLUS;
    if (roll < 97) return REQ_TIMER_MINUS;
    return ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
  endfunction

  // Mostly temperatures just around the set point so duty moves through its
  // whole range; the rest anywhere in the signed byte.
  function automatic logic [7:0] pick_temp();
    int tv;
    if ($urandom_range(0, 4) < 3) begin
      tv = cur_setpoint + $urandom_range(0, 32) - 4;
      if (tv > 127) tv = 127;
      return 8'(tv);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_AUTO_MODE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset, manual mode: limits, toggles, the whole timer ladder.
    send_req(REQ_TICK, 8'h80);          // manual tick leaves duty alone
    send_req(REQ_DUTY_DOWN, 8'h00);     // already at zero: limit beep
    send_req(REQ_TOGGLE, 8'h00);        // on, load PWM
    send_req(REQ_TOGGLE, 8'h00);        // off, no load
    send_req(REQ_TIMER_MINUS, 8'h00);   // at mode 0: bad beep
    send_req(REQ_TIMER_PLUS, 8'h00);
    send_req(REQ_TIMER_PLUS, 8'h00);
    send_req(REQ_TIMER_PLUS, 8'h00);
    send_req(REQ_TIMER_PLUS, 8'h00);    // at mode 3: bad beep
    send_req(REQ_TIMER_MINUS, 8'h00);
    send_req(REQ_TIMER_MINUS, 8'h00);
    send_req(REQ_TIMER_MINUS, 8'h00);   // back to mode 0, loads preset 0
    send_req(REQ_SPARE_LO, 8'hFF);
    send_req(REQ_SPARE_HI, 8'h7F);
    send_req(REQ_DUTY_UP, 8'h00);
    drain();

    // Automatic mode with set point 0: clamp, signed compare, step underflow,
    // timer expiring by countdown and with nothing left to count.
    apply_setting(1'b1, 7'd0, 8'd0, 8'd1, 8'd0, 8'd255);
    send_req(REQ_TICK, 8'h7F);          // far above: clamp to 100
    send_req(REQ_TICK, 8'hFF);          // -1 is below 0
    send_req(REQ_TICK, 8'h01);          // duty 4
    send_req(REQ_DUTY_DOWN, 8'h00);     // 4 drops to 0, not below
    send_req(REQ_DUTY_UP, 8'h00);       // ignored in automatic mode
    send_req(REQ_TOGGLE, 8'h00);
    send_req(REQ_TIMER_PLUS, 8'h00);    // mode 1, one tick left
    send_req(REQ_TICK, 8'h18);          // duty 96, timer runs out, fan off
    send_req(REQ_TIMER_PLUS, 8'h00);
    send_req(REQ_TIMER_PLUS, 8'h00);    // mode 2 with zero left
    send_req(REQ_TICK, 8'h18);          // expires without counting
    drain();

    // Manual again: step past the top, then sit on it.
    apply_setting(1'b0, 7'd127, 8'd255, 8'd255, 8'd255, 8'd255);
    send_req(REQ_DUTY_UP, 8'h00);       // 96 saturates at 100
    send_req(REQ_DUTY_UP, 8'h00);       // limit beep
    send_req(REQ_TICK, 8'h7F);
    drain();

    // Highest set point: a reading equal to it gives zero duty.
    apply_setting(1'b1, 7'd127, 8'd255, 8'd255, 8'd255, 8'd255);
    send_req(REQ_TICK, 8'h7F);
    send_req(REQ_TICK, 8'h80);
    drain();

    // Random phases: first all registers at their minimum, then at their
    // maximum, then random settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        apply_setting(1'b0, 7'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      end else if (ph == 1) begin
        apply_setting(1'b1, 7'd127, 8'd255, 8'd255, 8'd255, 8'd255);
      end else begin
        apply_setting(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                      pick_preset(), pick_preset(), pick_preset(), pick_preset());
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_req(pick_kind(), pick_temp());
      end
      drain();
    end

    repeat (8) @(negedge clk_i);
    $display("Sent %0d ticks, %0d toggles, %0d duty steps, %0d timer steps, %0d unused codes",
             kind_seen[REQ_TICK], kind_seen[REQ_TOGGLE],
             kind_seen[REQ_DUTY_UP] + kind_seen[REQ_DUTY_DOWN],
             kind_seen[REQ_TIMER_PLUS] + kind_seen[REQ_TIMER_MINUS],
             kind_seen[REQ_SPARE_LO] + kind_seen[REQ_SPARE_HI]);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             settings_done, checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
